@@ src/sqb_pkg.sv @@
// ----------------------------------------------------------------------------
// sqb_pkg
// Shared types and constants of the sprite quad batch builder.
// ----------------------------------------------------------------------------
package sqb_pkg;

   localparam int BATCH_MAX   = 2048;
   localparam int QUEUE_DEPTH = 2;
   localparam int CNT_W       = 12;

   localparam logic [1:0] REG_SPRITE_COLOR = 2'd0;
   localparam logic [1:0] REG_TEX_RECT     = 2'd1;
   localparam logic [1:0] REG_BATCH_LIMIT  = 2'd2;

   typedef enum logic [1:0] {
      CMD_BEGIN     = 2'd0,
      CMD_SPRITE_2D = 2'd1,
      CMD_SPRITE_3D = 2'd2,
      CMD_END       = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MARK,
      B_TRIG,
      B_TWAIT,
      B_CORNER,
      B_ROT,
      B_MUL,
      B_SUM
   } back_state_type;

   typedef struct packed {
      logic                has_marker;
      logic                has_sprite;
      logic                is_3d;
      logic [31:0]         mark_tex;
      logic [CNT_W-1:0]    mark_cnt;
      logic signed [31:0]  pos_x;
      logic signed [31:0]  pos_y;
      logic signed [31:0]  pos_z;
      logic signed [31:0]  size_w;
      logic signed [31:0]  size_h;
      logic signed [15:0]  angle_a;
      logic signed [15:0]  angle_x;
      logic signed [15:0]  angle_y;
   } job_type;

   typedef struct packed {
      logic               done;
      logic signed [16:0] c;
      logic signed [16:0] s;
   } trig_type;

endpackage

@@ src/sprite_quad_batch_builder_core.sv @@
// A draw marker is queued on acceptance, popped by the idle sequencer, then loaded into
// the output register. Per sprite: the job is fetched, angles picked, a CORDIC run
// follows per nonzero angle, then each corner is a plain 2D add, a 2D rotation or a
// 3D rotation per nonzero angle; a marker adds a step, output stalls add their length.
// One sprite is in the sequencer at a time; the next job is popped only from idle.
// Reset (synchronous): batch state, queue and sequencer clear, registers reload.
// ----------------------------------------------------------------------------
// sprite_quad_batch_builder_core
// Sprite command stream to batched quad vertices and draw markers.
// ----------------------------------------------------------------------------
module sprite_quad_batch_builder_core #(
   parameter int QUEUE_DEPTH = sqb_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_command,
   input  logic [31:0]        req_texture_id,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_size_w,
   input  logic signed [31:0] req_size_h,
   input  logic signed [15:0] req_angle_a,
   input  logic signed [15:0] req_angle_x,
   input  logic signed [15:0] req_angle_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic signed [31:0] rsp_vert_z,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic [31:0]        rsp_vertex_color,
   output logic [31:0]        rsp_draw_texture,
   output logic [11:0]        rsp_draw_count,
   output logic               rsp_last
);
   import sqb_pkg::*;

   logic [31:0]        color_ff;
   logic [63:0]        rect_ff;
   logic [11:0]        limit_ff;
   logic               q_push, q_pop, q_full, q_empty;
   job_type            q_in_data, q_head;
   logic               trig_start;
   logic signed [15:0] trig_angle;
   trig_type           trig;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= 32'hffffffff;
         rect_ff  <= 64'h8000800000000000;
         limit_ff <= 12'(BATCH_MAX);
      end else if (csr_write_en) begin
         case (csr_index)
            REG_SPRITE_COLOR: color_ff <= csr_wdata[31:0];
            REG_TEX_RECT:     rect_ff  <= csr_wdata;
            REG_BATCH_LIMIT:  limit_ff <= csr_wdata[11:0];
            default: begin
               color_ff <= color_ff;
            end
         endcase
      end
   end

   sqb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_texture_id (req_texture_id),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_size_w     (req_size_w),
      .req_size_h     (req_size_h),
      .req_angle_a    (req_angle_a),
      .req_angle_x    (req_angle_x),
      .req_angle_y    (req_angle_y),
      .batch_limit    (limit_ff),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_data         (q_in_data)
   );

   sqb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   sqb_sincos u_sincos (
      .clock (clock),
      .reset (reset),
      .start (trig_start),
      .angle (trig_angle),
      .trig  (trig)
   );

   sqb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (q_head),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .sprite_color     (color_ff),
      .tex_rect         (rect_ff),
      .trig_start       (trig_start),
      .trig_angle       (trig_angle),
      .trig             (trig),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_vert_x       (rsp_vert_x),
      .rsp_vert_y       (rsp_vert_y),
      .rsp_vert_z       (rsp_vert_z),
      .rsp_tex_u        (rsp_tex_u),
      .rsp_tex_v        (rsp_tex_v),
      .rsp_vertex_color (rsp_vertex_color),
      .rsp_draw_texture (rsp_draw_texture),
      .rsp_draw_count   (rsp_draw_count),
      .rsp_last         (rsp_last)
   );

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("job pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("job popped from empty queue");
   a_marker_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind) |-> (rsp_draw_count != 12'd0))
      else $error("draw marker with empty batch");
   a_vertex_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> (rsp_draw_count == 12'd0 && rsp_draw_texture == 32'd0))
      else $error("vertex carries draw fields");
`endif

endmodule

@@ src/sqb_front.sv @@
// ----------------------------------------------------------------------------
// sqb_front
// Accepts commands, tracks begin/end and batch state, builds back-end jobs.
// ----------------------------------------------------------------------------
module sqb_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_command,
   input  logic [31:0]                req_texture_id,
   input  logic signed [31:0]         req_pos_x,
   input  logic signed [31:0]         req_pos_y,
   input  logic signed [31:0]         req_pos_z,
   input  logic signed [31:0]         req_size_w,
   input  logic signed [31:0]         req_size_h,
   input  logic signed [15:0]         req_angle_a,
   input  logic signed [15:0]         req_angle_x,
   input  logic signed [15:0]         req_angle_y,
   input  logic [11:0]                batch_limit,
   input  logic                       q_full,
   output logic                       q_push,
   output sqb_pkg::job_type           q_data
);
   import sqb_pkg::*;

   logic             active_ff, active_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      tex_ff, tex_in;
   logic [CNT_W-1:0] lim, count0;
   logic             accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   always_comb begin
      lim = batch_limit;
      if (batch_limit > 12'(BATCH_MAX)) begin
         lim = 12'(BATCH_MAX);
      end
      if (batch_limit == '0) begin
         lim = 12'd1;
      end
      active_in = active_ff;
      count_in  = count_ff;
      tex_in    = tex_ff;
      count0    = count_ff;
      q_data            = '0;
      q_data.is_3d      = (cmd_type'(req_command) == CMD_SPRITE_3D);
      q_data.pos_x      = req_pos_x;
      q_data.pos_y      = req_pos_y;
      q_data.pos_z      = req_pos_z;
      q_data.size_w     = req_size_w;
      q_data.size_h     = req_size_h;
      q_data.angle_a    = req_angle_a;
      q_data.angle_x    = req_angle_x;
      q_data.angle_y    = req_angle_y;
      q_data.mark_tex   = tex_ff;
      q_data.mark_cnt   = count_ff;
      case (cmd_type'(req_command))
         CMD_BEGIN: begin
            if (!active_ff) begin
               active_in = 1'b1;
               count_in  = '0;
               tex_in    = '0;
            end
         end
         CMD_END: begin
            if (active_ff) begin
               q_data.has_marker = (count_ff != '0);
               count_in  = '0;
               active_in = 1'b0;
            end
         end
         CMD_SPRITE_2D, CMD_SPRITE_3D: begin
            if (active_ff) begin
               if (req_texture_id != tex_ff) begin
                  q_data.has_marker = (count_ff != '0);
                  count0 = '0;
                  tex_in = req_texture_id;
               end else if (count_ff >= lim) begin
                  q_data.has_marker = 1'b1;
                  count0 = '0;
               end
               q_data.has_sprite = 1'b1;
               count_in = count0 + 12'd1;
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase
      q_push = accept && (q_data.has_marker || q_data.has_sprite);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         tex_ff    <= '0;
      end else if (accept) begin
         active_ff <= active_in;
         count_ff  <= count_in;
         tex_ff    <= tex_in;
      end
   end

endmodule

@@ src/sqb_queue.sv @@
// ----------------------------------------------------------------------------
// sqb_queue
// Short job queue between the front end and the vertex sequencer.
// ----------------------------------------------------------------------------
module sqb_queue #(
   parameter int DEPTH = sqb_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sqb_pkg::job_type push_data,
   input  logic             pop,
   output sqb_pkg::job_type head,
   output logic             full,
   output logic             empty
);
   import sqb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   cnt_ff;

   assign head  = mem_ff[rd_ff];
   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      if (p == PW'(DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= next_ptr(wr_ff);
         end
         if (pop) begin
            rd_ff <= next_ptr(rd_ff);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

endmodule

@@ src/sqb_sincos.sv @@
// ----------------------------------------------------------------------------
// sqb_sincos
// Iterative CORDIC sine/cosine, Q2.15 result, one rotation step per cycle.
// ----------------------------------------------------------------------------
module sqb_sincos (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] angle,
   output sqb_pkg::trig_type  trig
);
   import sqb_pkg::*;

   logic               run_ff, done_ff;
   logic [3:0]         i_ff;
   logic [1:0]         q_ff, q_in;
   logic signed [24:0] z_ff, z_in, z_n;
   logic signed [33:0] x_ff, y_ff, x_n, y_n, xs, ys;
   logic signed [16:0] c_ff, s_ff, cc, ss, c_in, s_in;
   logic signed [17:0] v;
   logic [14:0]        r, res;

   function automatic logic [21:0] atan_step(input logic [3:0] i);
      case (i)
         4'd0:    return 22'd2949120;
         4'd1:    return 22'd1740967;
         4'd2:    return 22'd919879;
         4'd3:    return 22'd466945;
         4'd4:    return 22'd234379;
         4'd5:    return 22'd117304;
         4'd6:    return 22'd58666;
         4'd7:    return 22'd29335;
         4'd8:    return 22'd14668;
         4'd9:    return 22'd7334;
         4'd10:   return 22'd3667;
         4'd11:   return 22'd1833;
         4'd12:   return 22'd917;
         4'd13:   return 22'd458;
         4'd14:   return 22'd229;
         default: return 22'd115;
      endcase
   endfunction

   function automatic logic signed [16:0] round_clamp(input logic signed [33:0] a);
      logic signed [33:0] t;
      t = (a + 34'sd16384) >>> 15;
      if (t > 34'sd32768) begin
         return 17'sd32768;
      end
      if (t < -34'sd32768) begin
         return -17'sd32768;
      end
      return t[16:0];
   endfunction

   always_comb begin
      v = 18'(angle) + 18'sd46080;
      if (v >= 18'sd46080) begin
         v = v - 18'sd46080;
      end
      if (v >= 18'sd23040) begin
         v = v - 18'sd23040;
      end
      r = v[14:0];
      if (r >= 15'd17280) begin
         q_in = 2'd3;
         res  = r - 15'd17280;
      end else if (r >= 15'd11520) begin
         q_in = 2'd2;
         res  = r - 15'd11520;
      end else if (r >= 15'd5760) begin
         q_in = 2'd1;
         res  = r - 15'd5760;
      end else begin
         q_in = 2'd0;
         res  = r;
      end
      z_in = $signed({res, 10'd0});
   end

   always_comb begin
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      if (!z_ff[24]) begin
         x_n = x_ff - ys;
         y_n = y_ff + xs;
         z_n = z_ff - $signed({3'd0, atan_step(i_ff)});
      end else begin
         x_n = x_ff + ys;
         y_n = y_ff - xs;
         z_n = z_ff + $signed({3'd0, atan_step(i_ff)});
      end
      cc = round_clamp(x_n);
      ss = round_clamp(y_n);
      case (q_ff)
         2'd0: begin
            c_in = cc;
            s_in = ss;
         end
         2'd1: begin
            c_in = -ss;
            s_in = cc;
         end
         2'd2: begin
            c_in = -cc;
            s_in = -ss;
         end
         default: begin
            c_in = ss;
            s_in = -cc;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (i_ff == 4'd15);
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (i_ff == 4'd15)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         i_ff <= '0;
         q_ff <= q_in;
         z_ff <= z_in;
         x_ff <= 34'sd652032874;
         y_ff <= '0;
      end else if (run_ff) begin
         i_ff <= i_ff + 4'd1;
         z_ff <= z_n;
         x_ff <= x_n;
         y_ff <= y_n;
         if (i_ff == 4'd15) begin
            c_ff <= c_in;
            s_ff <= s_in;
         end
      end
   end

   assign trig.done = done_ff;
   assign trig.c    = c_ff;
   assign trig.s    = s_ff;

endmodule

@@ src/sqb_back.sv @@
// ----------------------------------------------------------------------------
// sqb_back
// Vertex sequencer: draw markers, corner rotation, output register.
// ----------------------------------------------------------------------------
module sqb_back (
   input  logic               clock,
   input  logic               reset,
   input  sqb_pkg::job_type   job,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic [31:0]        sprite_color,
   input  logic [63:0]        tex_rect,
   output logic               trig_start,
   output logic signed [15:0] trig_angle,
   input  sqb_pkg::trig_type  trig,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic signed [31:0] rsp_vert_x,
   output logic signed [31:0] rsp_vert_y,
   output logic signed [31:0] rsp_vert_z,
   output logic [15:0]        rsp_tex_u,
   output logic [15:0]        rsp_tex_v,
   output logic [31:0]        rsp_vertex_color,
   output logic [31:0]        rsp_draw_texture,
   output logic [11:0]        rsp_draw_count,
   output logic               rsp_last
);
   import sqb_pkg::*;

   back_state_type     state_ff, state_in;
   job_type            job_ff, job_in;
   logic [1:0]         idx_ff, idx_in, k_ff, k_in, r_ff, r_in;
   logic signed [16:0] c_ff [3];
   logic signed [16:0] s_ff [3];
   logic               cs_we;
   logic signed [35:0] lx_ff, ly_ff, lz_ff, lx_in, ly_in, lz_in;
   logic signed [52:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic               mul_en;
   logic signed [31:0] vx_ff, vy_ff, vz_ff, vx_in, vy_in, vz_in;
   logic               slot_free, out_load, out_mark;
   logic signed [35:0] sel_a, sel_b, na, nb;
   logic signed [16:0] sel_c, sel_s;
   logic signed [15:0] rot_ang;
   logic signed [55:0] sum_p, sum_q;
   logic               gx, gy;

   function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
      if (v > 56'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (v < -56'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   assign slot_free = !rsp_valid || !rsp_stall;
   assign gx        = (k_ff == 2'd1) || (k_ff == 2'd2);
   assign gy        = k_ff[1];

   always_comb begin
      case (r_ff)
         2'd0: begin
            sel_a   = lx_ff;
            sel_b   = ly_ff;
            rot_ang = job_ff.angle_a;
         end
         2'd1: begin
            sel_a   = ly_ff;
            sel_b   = lz_ff;
            rot_ang = job_ff.angle_x;
         end
         default: begin
            sel_a   = lz_ff;
            sel_b   = lx_ff;
            rot_ang = job_ff.angle_y;
         end
      endcase
      case (r_ff)
         2'd0: begin
            sel_c = c_ff[0];
            sel_s = s_ff[0];
         end
         2'd1: begin
            sel_c = c_ff[1];
            sel_s = s_ff[1];
         end
         default: begin
            sel_c = c_ff[2];
            sel_s = s_ff[2];
         end
      endcase
      case (idx_ff)
         2'd0:    trig_angle = job_ff.angle_a;
         2'd1:    trig_angle = job_ff.angle_x;
         default: trig_angle = job_ff.angle_y;
      endcase
      sum_p = 56'(p1_ff) - 56'(p2_ff);
      sum_q = 56'(p3_ff) + 56'(p4_ff);
      na    = 36'((sum_p + 56'sd16384) >>> 15);
      nb    = 36'((sum_q + 56'sd16384) >>> 15);
   end

   always_comb begin
      state_in   = state_ff;
      job_in     = job_ff;
      idx_in     = idx_ff;
      k_in       = k_ff;
      r_in       = r_ff;
      lx_in      = lx_ff;
      ly_in      = ly_ff;
      lz_in      = lz_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      vz_in      = vz_ff;
      q_pop      = 1'b0;
      trig_start = 1'b0;
      cs_we      = 1'b0;
      mul_en     = 1'b0;
      out_load   = 1'b0;
      out_mark   = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = job;
               idx_in   = '0;
               k_in     = '0;
               state_in = job.has_marker ? B_MARK : B_TRIG;
            end
         end
         B_MARK: begin
            if (slot_free) begin
               out_load = 1'b1;
               out_mark = 1'b1;
               state_in = job_ff.has_sprite ? B_TRIG : B_IDLE;
            end
         end
         B_TRIG: begin
            if (idx_ff == 2'd3) begin
               state_in = B_CORNER;
            end else if ((trig_angle != '0) && ((idx_ff == 2'd0) || job_ff.is_3d)) begin
               trig_start = 1'b1;
               state_in   = B_TWAIT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         B_TWAIT: begin
            if (trig.done) begin
               cs_we    = 1'b1;
               idx_in   = idx_ff + 2'd1;
               state_in = B_TRIG;
            end
         end
         B_CORNER: begin
            if (!job_ff.is_3d && (job_ff.angle_a == '0)) begin
               vx_in = sat32(56'(job_ff.pos_x) + (gx ? 56'(job_ff.size_w) : 56'sd0));
               vy_in = sat32(56'(job_ff.pos_y) + (gy ? 56'(job_ff.size_h) : 56'sd0));
               vz_in = '0;
               state_in = B_SUM;
            end else begin
               lx_in    = gx ? 36'(job_ff.size_w) : -36'(job_ff.size_w);
               ly_in    = gy ? 36'(job_ff.size_h) : -36'(job_ff.size_h);
               lz_in    = '0;
               r_in     = '0;
               state_in = B_ROT;
            end
         end
         B_ROT: begin
            if (!job_ff.is_3d) begin
               mul_en   = 1'b1;
               state_in = B_MUL;
            end else if (r_ff == 2'd3) begin
               vx_in = sat32((56'(job_ff.pos_x) * 2 + 56'(lx_ff) + 56'sd1) >>> 1);
               vy_in = sat32((56'(job_ff.pos_y) * 2 + 56'(ly_ff) + 56'sd1) >>> 1);
               vz_in = sat32((56'(job_ff.pos_z) * 2 + 56'(lz_ff) + 56'sd1) >>> 1);
               state_in = B_SUM;
            end else if (rot_ang != '0) begin
               mul_en   = 1'b1;
               state_in = B_MUL;
            end else begin
               r_in = r_ff + 2'd1;
            end
         end
         B_MUL: begin
            if (!job_ff.is_3d) begin
               vx_in = sat32((sum_p + ((56'(job_ff.pos_x) * 2 + 56'(job_ff.size_w)) <<< 15)
                              + 56'sd32768) >>> 16);
               vy_in = sat32((sum_q + ((56'(job_ff.pos_y) * 2 + 56'(job_ff.size_h)) <<< 15)
                              + 56'sd32768) >>> 16);
               vz_in = '0;
               state_in = B_SUM;
            end else begin
               case (r_ff)
                  2'd0: begin
                     lx_in = na;
                     ly_in = nb;
                  end
                  2'd1: begin
                     ly_in = na;
                     lz_in = nb;
                  end
                  default: begin
                     lz_in = na;
                     lx_in = nb;
                  end
               endcase
               r_in     = r_ff + 2'd1;
               state_in = B_ROT;
            end
         end
         B_SUM: begin
            if (slot_free) begin
               out_load = 1'b1;
               if (k_ff == 2'd3) begin
                  state_in = B_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = B_CORNER;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      idx_ff <= idx_in;
      k_ff   <= k_in;
      r_ff   <= r_in;
      lx_ff  <= lx_in;
      ly_ff  <= ly_in;
      lz_ff  <= lz_in;
      vx_ff  <= vx_in;
      vy_ff  <= vy_in;
      vz_ff  <= vz_in;
      if (cs_we) begin
         case (idx_ff)
            2'd0: begin
               c_ff[0] <= trig.c;
               s_ff[0] <= trig.s;
            end
            2'd1: begin
               c_ff[1] <= trig.c;
               s_ff[1] <= trig.s;
            end
            default: begin
               c_ff[2] <= trig.c;
               s_ff[2] <= trig.s;
            end
         endcase
      end
      if (mul_en) begin
         p1_ff <= sel_a * sel_c;
         p2_ff <= sel_b * sel_s;
         p3_ff <= sel_a * sel_s;
         p4_ff <= sel_b * sel_c;
      end
      if (out_load) begin
         rsp_kind <= out_mark;
         if (out_mark) begin
            rsp_vert_x       <= '0;
            rsp_vert_y       <= '0;
            rsp_vert_z       <= '0;
            rsp_tex_u        <= '0;
            rsp_tex_v        <= '0;
            rsp_vertex_color <= '0;
            rsp_draw_texture <= job_ff.mark_tex;
            rsp_draw_count   <= job_ff.mark_cnt;
            rsp_last         <= !job_ff.has_sprite;
         end else begin
            rsp_vert_x       <= vx_ff;
            rsp_vert_y       <= vy_ff;
            rsp_vert_z       <= vz_ff;
            rsp_tex_u        <= gx ? tex_rect[47:32] : tex_rect[15:0];
            rsp_tex_v        <= gy ? tex_rect[31:16] : tex_rect[63:48];
            rsp_vertex_color <= sprite_color;
            rsp_draw_texture <= '0;
            rsp_draw_count   <= '0;
            rsp_last         <= (k_ff == 2'd3);
         end
      end
   end

endmodule
